[src/assert_macros.svh]
// assertion macros shared by the frame store rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[src/bplfs_pkg.sv]
// shared constants, codes and item types of the bit-plane led frame store
package bplfs_pkg;

	localparam int LED_COUNT     = 256;
	localparam int WORDS_PER_BUF = 24 * LED_COUNT;
	localparam int MEM_DEPTH     = 2 * WORDS_PER_BUF;
	localparam int ADDR_W        = $clog2(MEM_DEPTH);

	localparam int WORD_W  = 32;
	localparam int LANE_W  = 5;
	localparam int BITS_W  = 6;
	// 32 * 255 + 32 needs 14 bits
	localparam int SPAN_W  = 14;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic REG_CHANNEL_FORMATS = 1'b0;

	localparam logic [1:0] MODE_SET  = 2'd0;
	localparam logic [1:0] MODE_GET  = 2'd1;
	localparam logic [1:0] MODE_SWAP = 2'd2;
	localparam logic [1:0] MODE_TICK = 2'd3;

	localparam logic [1:0] FMT_RGB  = 2'd0;
	localparam logic [1:0] FMT_GRB  = 2'd1;
	localparam logic [1:0] FMT_GRBW = 2'd2;
	localparam logic [1:0] FMT_BAD  = 2'd3;

	localparam logic [BITS_W-1:0] BITS_RGB  = BITS_W'(24);
	localparam logic [BITS_W-1:0] BITS_GRBW = BITS_W'(32);

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] channel;
		logic [7:0] led;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
		logic       to_inactive;
	} in_item_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] white_out;
		logic       shown_buffer;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic              write;
		logic [ADDR_W-1:0] addr;
		logic [BITS_W-1:0] count;
		logic [LANE_W-1:0] lane;
		logic [WORD_W-1:0] val;
	} eng_req_t;

	typedef struct packed {
		logic              clearing;
		logic              done;
		logic [WORD_W-1:0] acc;
	} eng_rsp_t;

	function automatic logic [BITS_W-1:0] format_bits(input logic [1:0] fmt);
		logic [BITS_W-1:0] n;
		case (fmt)
			FMT_RGB, FMT_GRB: n = BITS_RGB;
			FMT_GRBW:         n = BITS_GRBW;
			default:          n = '0;
		endcase
		return n;
	endfunction

endpackage

[src/bplfs_engine.sv]
// word memory with clearing pass and bit-serial read, or read-modify-write, of one lane
`include "assert_macros.svh"

module bplfs_engine import bplfs_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  eng_req_t req,
	output eng_rsp_t rsp
);

	logic [WORD_W-1:0] mem [MEM_DEPTH];

	logic              clearing_q;
	logic [ADDR_W-1:0] clr_q;
	logic              run_q;
	logic              done_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BITS_W-1:0] left_q;
	logic              write_q;
	logic [LANE_W-1:0] lane_q;
	logic [WORD_W-1:0] val_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] rdata_q;

	logic              rd_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic              bit_s1;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
			run_q      <= 1'b0;
			rd_s1      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_q == ADDR_W'(MEM_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && left_q == BITS_W'(1)) begin
				run_q <= 1'b0;
			end
			rd_s1  <= run_q;
			done_q <= rd_s1 && !run_q;
		end
	end

	// serial datapath: one word address and one colour bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			addr_q  <= req.addr;
			left_q  <= req.count;
			write_q <= req.write;
			lane_q  <= req.lane;
			val_q   <= req.val;
			acc_q   <= '0;
		end else begin
			if (run_q) begin
				addr_q <= addr_q + ADDR_W'(1);
				left_q <= left_q - BITS_W'(1);
				val_q  <= {val_q[WORD_W-2:0], 1'b0};
			end
			if (rd_s1 && !write_q) begin
				acc_q <= {acc_q[WORD_W-2:0], rdata_q[lane_q]};
			end
		end
		wa_s1  <= addr_q;
		bit_s1 <= val_q[WORD_W-1];
	end

	always_comb begin
		merged         = rdata_q;
		merged[lane_q] = bit_s1;
		wr_en          = clearing_q || (rd_s1 && write_q);
		wr_addr        = clearing_q ? clr_q : wa_s1;
		wr_data        = clearing_q ? '0 : merged;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[addr_q];
	end

	assign rsp.clearing = clearing_q;
	assign rsp.done     = done_q;
	assign rsp.acc      = acc_q;

	`ASSERT_IMP(a_no_run_in_clear, clk, arst_n, clearing_q, !run_q && !rd_s1)
	`ASSERT_IMP(a_start_when_idle, clk, arst_n, req.start, !run_q && !rd_s1 && !clearing_q)
	`ASSERT_NXT(a_run_feeds_stage, clk, arst_n, run_q, rd_s1)

endmodule

[src/bit_plane_led_frame_store_core.sv]
// top level of the double-buffered bit-plane frame store for 32 led strings
// set/get walk N = 24 or 32 colour bits through the engine, then its done flag, done state and result register
// swap, tick and refused items go from accept straight to the done state; a new item waits for the result register
// one memory word read per colour bit, and rewritten for sets, through a ram with one read and one write port
// after reset the store is cleared, one word per cycle over all 12288 words, with input stalled
// reset clears formats, active buffer, swap flag and handshake state; config always taken
`include "assert_macros.svh"

module bit_plane_led_frame_store_core import bplfs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// request items
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	// result items
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [CFG_DATA_W-1:0] formats_q;
	logic                  active_q;
	logic                  swap_pending_q;
	logic [1:0]            state_q;
	logic                  out_valid_q;

	// payload of the item in flight and of the result register
	out_item_t   res_q;
	out_item_t   out_q;
	logic [1:0]  mode_q;
	logic [1:0]  fmt_q;

	eng_req_t    eng_req;
	eng_rsp_t    eng_rsp;

	logic              reg_idx;
	logic              cfg_wr;
	logic              accept;
	logic [1:0]        fmt;
	logic [BITS_W-1:0] bits;
	logic [SPAN_W-1:0] base;
	logic [SPAN_W-1:0] span_end;
	logic              loc_ok;
	logic              is_mem;
	logic              buf_sel;
	logic              active_nxt;
	logic              out_free;
	logic [7:0]        r_unp;
	logic [7:0]        g_unp;
	logic [7:0]        b_unp;
	logic [7:0]        w_unp;

	// register port: one 64-bit register, index taken from the upper address bit
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == REG_CHANNEL_FORMATS) ? formats_q : '0;

	// decode of the incoming item
	assign accept   = in_valid && !in_stall;
	assign in_stall = eng_rsp.clearing || (state_q != ST_IDLE);
	assign fmt      = formats_q[{in_data.channel, 1'b0} +: 2];
	assign bits     = format_bits(fmt);
	assign base     = SPAN_W'(bits) * SPAN_W'(in_data.led);
	assign span_end = base + SPAN_W'(bits);
	// words must stay inside one buffer; led must be below LED_COUNT
	assign loc_ok   = (fmt != FMT_BAD) && (int'(in_data.led) < LED_COUNT)
		&& (int'(span_end) <= WORDS_PER_BUF);
	assign is_mem   = ((in_data.mode == MODE_SET) || (in_data.mode == MODE_GET)) && loc_ok;
	// sets may target the hidden buffer, gets always read the shown one
	assign buf_sel  = (in_data.mode == MODE_SET) ? (active_q ^ in_data.to_inactive) : active_q;

	always_comb begin
		active_nxt = active_q;
		if (in_data.mode == MODE_TICK && swap_pending_q) begin
			active_nxt = !active_q;
		end
	end

	// colour packed msb first; grb and grbw put green on top
	always_comb begin
		eng_req.start = accept && is_mem;
		eng_req.write = (in_data.mode == MODE_SET);
		eng_req.addr  = ADDR_W'(base) + (buf_sel ? ADDR_W'(WORDS_PER_BUF) : ADDR_W'(0));
		eng_req.count = bits;
		eng_req.lane  = in_data.channel;
		if (fmt == FMT_RGB) begin
			eng_req.val = {in_data.red, in_data.green, in_data.blue, 8'h00};
		end else begin
			eng_req.val = {in_data.green, in_data.red, in_data.blue,
				(fmt == FMT_GRBW) ? in_data.white : 8'h00};
		end
	end

	bplfs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (eng_req),
		.rsp    (eng_rsp)
	);

	// unpack the gathered bits, last bit read sits in bit 0
	always_comb begin
		w_unp = 8'h00;
		b_unp = eng_rsp.acc[7:0];
		r_unp = eng_rsp.acc[23:16];
		g_unp = eng_rsp.acc[15:8];
		case (fmt_q)
			FMT_RGB: begin
				r_unp = eng_rsp.acc[23:16];
				g_unp = eng_rsp.acc[15:8];
				b_unp = eng_rsp.acc[7:0];
			end
			FMT_GRB: begin
				g_unp = eng_rsp.acc[23:16];
				r_unp = eng_rsp.acc[15:8];
				b_unp = eng_rsp.acc[7:0];
			end
			FMT_GRBW: begin
				g_unp = eng_rsp.acc[31:24];
				r_unp = eng_rsp.acc[23:16];
				b_unp = eng_rsp.acc[15:8];
				w_unp = eng_rsp.acc[7:0];
			end
			default: begin
				w_unp = 8'h00;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	// control: formats, buffer flags and item sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			formats_q      <= '0;
			active_q       <= 1'b0;
			swap_pending_q <= 1'b0;
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr && reg_idx == REG_CHANNEL_FORMATS) begin
				formats_q <= pwdata;
			end
			// a new result replaces the one taken in the same cycle
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						active_q <= active_nxt;
						if (in_data.mode == MODE_SWAP) begin
							swap_pending_q <= 1'b1;
						end else if (in_data.mode == MODE_TICK) begin
							swap_pending_q <= 1'b0;
						end
						state_q <= is_mem ? ST_WAIT : ST_DONE;
					end
				end
				ST_WAIT: begin
					if (eng_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload follows the same sequencing
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			mode_q             <= in_data.mode;
			fmt_q              <= fmt;
			res_q.ok           <= ((in_data.mode == MODE_SET) || (in_data.mode == MODE_GET))
				? loc_ok : 1'b1;
			res_q.red_out      <= 8'h00;
			res_q.green_out    <= 8'h00;
			res_q.blue_out     <= 8'h00;
			res_q.white_out    <= 8'h00;
			res_q.shown_buffer <= active_nxt;
		end
		if (state_q == ST_WAIT && eng_rsp.done && mode_q == MODE_GET) begin
			res_q.red_out   <= r_unp;
			res_q.green_out <= g_unp;
			res_q.blue_out  <= b_unp;
			res_q.white_out <= w_unp;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_NXT(a_accept_then_busy, clk, arst_n, accept, in_stall)
	`ASSERT_IMP(a_done_only_waiting, clk, arst_n, eng_rsp.done, state_q == ST_WAIT)
	// colour fields sit between ok and shown_buffer
	`ASSERT_IMP(a_refused_no_colour, clk, arst_n, out_valid_q && !out_q.ok, out_q[32:1] == '0)

endmodule

[test/tb_bit_plane_led_frame_store_core.sv]
// testbench for the bit-plane led frame store: queued driver, checking monitor, own predictor
module tb_bit_plane_led_frame_store_core;
	import bplfs_pkg::*;

	// the store clear after reset keeps the input stalled until all 12288 words are cleared
	localparam int QUIET_LIMIT = 40000;
	localparam int LONG_HOLD   = 400;
	localparam int END_CYCLES  = 50;
	localparam int IGNORED_REG = 1;
	localparam int NUM_PHASES  = 8;
	localparam int POOL_DEPTH  = 16;
	localparam logic [CFG_ADDR_W-1:0] FORMATS_ADDR = CFG_ADDR_W'(8 * REG_CHANNEL_FORMATS);

	typedef struct {
		in_item_t item;
		bit       drain_first;	// hold this item back until every result is in
	} queued_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// predictor state: both frame buffers, shown buffer, armed swap, format register
	bit [WORD_W-1:0] frame_words [2][WORDS_PER_BUF];
	bit              shown_idx;
	bit              swap_armed;
	logic [63:0]     formats_model;

	queued_item_t pending_items [$];
	out_item_t    expected_results [$];
	logic [12:0]  written_spots [$];	// {channel, led} of recent sets

	bit idle_on = 1'b1;
	bit hold_kick = 1'b0;
	bit hold_seen = 1'b0;
	int send_gap = 0;
	int recv_wait = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int results_checked = 0;
	int set_count = 0;
	int get_count = 0;
	int flip_count = 0;
	int refused_count = 0;
	int settings_count = 0;

	bit_plane_led_frame_store_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		// cap the printout, keep counting
		if (mismatch_count < 30)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h", results_checked, name,
				got, want));
	endtask

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 7) : 0;
	endfunction

	// expected result of one item, updating the predicted store as the block would
	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t   r;
		logic [1:0]  fmt;
		int          bits;
		int          base;
		int          buf_idx;
		logic [31:0] val;
		logic [31:0] acc;
		r = '0;
		fmt = formats_model[2 * it.channel +: 2];
		case (fmt)
			FMT_RGB, FMT_GRB: bits = 24;
			FMT_GRBW:         bits = 32;
			default:          bits = 0;
		endcase
		base = bits * it.led;
		if (it.mode == MODE_SET || it.mode == MODE_GET) begin
			// bad format, led beyond the string, or words past the buffer end: refused
			if (bits != 0 && it.led < LED_COUNT && base + bits <= WORDS_PER_BUF) begin
				r.ok = 1'b1;
				if (it.mode == MODE_SET) begin
					buf_idx = shown_idx ^ it.to_inactive;
					if (fmt == FMT_RGB)
						val = {it.red, it.green, it.blue, 8'h00};
					else
						val = {it.green, it.red, it.blue, (fmt == FMT_GRBW) ? it.white : 8'h00};
					// msb first, one word per colour bit, only this channel's lane
					for (int i = 0; i < bits; i++)
						frame_words[buf_idx][base + i][it.channel] = val[31 - i];
				end else begin
					acc = '0;
					for (int i = 0; i < bits; i++)
						acc = {acc[30:0], frame_words[shown_idx][base + i][it.channel]};
					if (fmt == FMT_GRBW) begin
						r.white_out = acc[7:0];
						acc = acc >> 8;
					end
					r.blue_out = acc[7:0];
					if (fmt == FMT_RGB) begin
						r.green_out = acc[15:8];
						r.red_out   = acc[23:16];
					end else begin
						r.red_out   = acc[15:8];
						r.green_out = acc[23:16];
					end
				end
			end
		end else if (it.mode == MODE_SWAP) begin
			swap_armed = 1'b1;
			r.ok = 1'b1;
		end else begin
			// blanking tick flips only when a swap is armed
			if (swap_armed) begin
				shown_idx = ~shown_idx;
				swap_armed = 1'b0;
			end
			r.ok = 1'b1;
		end
		r.shown_buffer = shown_idx;
		return r;
	endfunction

	function automatic in_item_t make_item(input logic [1:0] mode, input int ch, input int led,
		input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
		input logic [7:0] white, input bit hidden);
		in_item_t it;
		it.mode        = mode;
		it.channel     = 5'(ch);
		it.led         = 8'(led);
		it.red         = red;
		it.green       = green;
		it.blue        = blue;
		it.white       = white;
		it.to_inactive = hidden;
		return it;
	endfunction

	task automatic push_item(input in_item_t it, input bit drain);
		queued_item_t q;
		q.item = it;
		q.drain_first = drain;
		pending_items.push_back(q);
	endtask

	// register write, then read the format register back
	task automatic program_formats(input int index, input logic [63:0] value);
		logic [63:0] readback;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_W'(8 * index);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (index == REG_CHANNEL_FORMATS)
			formats_model = value;
		settings_count++;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= FORMATS_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (readback !== formats_model)
			report_mismatch($sformatf("format register read %h want %h", readback,
				formats_model));
	endtask

	// nothing queued, nothing offered, nothing outstanding
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	// mostly set/get pairs on recent spots plus swaps and ticks, some pure noise
	task automatic add_random_items(input int count);
		for (int n = 0; n < count; n++) begin
			in_item_t    it;
			logic [63:0] raw;
			logic [12:0] spot;
			int          pick;
			raw = {$urandom, $urandom};
			it = raw[$bits(in_item_t)-1:0];
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				it.mode = MODE_SET;
				if (written_spots.size() != 0 && $urandom_range(0, 3) == 0) begin
					spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
					{it.channel, it.led} = spot;
				end
				written_spots.push_back({it.channel, it.led});
				if (written_spots.size() > POOL_DEPTH)
					written_spots.pop_front();
			end else if (pick < 70) begin
				it.mode = MODE_GET;
				if (written_spots.size() != 0 && $urandom_range(0, 3) != 0) begin
					spot = written_spots[$urandom_range(0, written_spots.size() - 1)];
					{it.channel, it.led} = spot;
				end
			end else if (pick < 80) begin
				it.mode = MODE_SWAP;
			end else if (pick < 90) begin
				it.mode = MODE_TICK;
			end
			push_item(it, n == count / 2);
		end
	endtask

	// driver: offers queued items, predicts each one as it is accepted
	always @(posedge clk) begin
		bit offering;
		out_item_t want;
		offering = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = predict_result(in_data);
				expected_results.push_back(want);
				items_sent++;
				case (in_data.mode)
					MODE_SET: set_count++;
					MODE_GET: get_count++;
					default:  flip_count++;
				endcase
				if (!want.ok)
					refused_count++;
				offering = 1'b0;
				send_gap = draw_gap();
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() != 0 &&
					!(pending_items[0].drain_first && expected_results.size() != 0)) begin
					in_data <= pending_items[0].item;
					pending_items.pop_front();
					offering = 1'b1;
				end
			end
		end
		in_valid <= offering;
	end

	// monitor: checks accepted results in order and drives the receiver stall
	always @(posedge clk) begin
		bit stall_next;
		out_item_t want;
		stall_next = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no item waiting for it");
				end else begin
					want = expected_results.pop_front();
					compare_field("ok", 8'(out_data.ok), 8'(want.ok));
					compare_field("red_out", out_data.red_out, want.red_out);
					compare_field("green_out", out_data.green_out, want.green_out);
					compare_field("blue_out", out_data.blue_out, want.blue_out);
					compare_field("white_out", out_data.white_out, want.white_out);
					compare_field("shown_buffer", 8'(out_data.shown_buffer),
						8'(want.shown_buffer));
				end
				results_checked++;
				recv_wait = draw_gap();
			end
			// a long hold-off lets the block back up into its input
			if (hold_kick != hold_seen) begin
				hold_seen = hold_kick;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				stall_next = 1'b1;
			end
		end
		out_stall <= stall_next;
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: %0d cycles without progress", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [63:0] phase_formats [NUM_PHASES];
		int          phase_len [NUM_PHASES];
		shown_idx = 1'b0;
		swap_armed = 1'b0;
		formats_model = '0;
		phase_formats = '{{$urandom, $urandom}, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555, {$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF,
			{$urandom, $urandom}, {$urandom, $urandom}};
		phase_len = '{220, 180, 180, 180, 220, 60, 220, 100};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// ch0 rgb, ch1 grb, ch2 grbw, ch3 bad format, ch31 grbw
		program_formats(REG_CHANNEL_FORMATS, 64'h8000_0000_0000_00E4);
		push_item(make_item(MODE_SET, 0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_SET, 1, 255, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 1, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
		push_item(make_item(MODE_SET, 2, 191, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 2, 191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// grbw words would run past the buffer end
		push_item(make_item(MODE_SET, 2, 192, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 2, 255, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// invalid format refused for set and get
		push_item(make_item(MODE_SET, 3, 0, 8'h11, 8'h22, 8'h33, 8'h44, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 3, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// write the hidden buffer, shown one stays clear
		push_item(make_item(MODE_SET, 31, 0, 8'h81, 8'h42, 8'h24, 8'h18, 1'b1), 1'b0);
		push_item(make_item(MODE_GET, 31, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// tick with no swap armed
		push_item(make_item(MODE_TICK, 31, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
		push_item(make_item(MODE_GET, 31, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// repeated swap requests flip only once
		push_item(make_item(MODE_SWAP, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_SWAP, 31, 255, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
		push_item(make_item(MODE_TICK, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_TICK, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 31, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		// clear the lane in the now hidden buffer 0, then flip back
		push_item(make_item(MODE_SET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1), 1'b0);
		push_item(make_item(MODE_SWAP, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_TICK, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 0, 0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		push_item(make_item(MODE_GET, 1, 255, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		wait_idle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			// one write to a register index that the block ignores
			if (p == 2)
				program_formats(IGNORED_REG, {$urandom, $urandom});
			program_formats(REG_CHANNEL_FORMATS, phase_formats[p]);
			idle_on = (p != 3);
			add_random_items(phase_len[p]);
			// receiver backs off while the sender keeps offering
			if (p == 1)
				hold_kick <= ~hold_kick;
			wait_idle();
		end

		repeat (END_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		$display("ran %0d items (%0d set, %0d get, %0d swap/tick), %0d refused, %0d checked",
			items_sent, set_count, get_count, flip_count, refused_count, results_checked);
		$display("over %0d register writes, with long receiver hold-off and drained pauses",
			settings_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/bplfs_pkg.sv
src/bplfs_engine.sv
src/bit_plane_led_frame_store_core.sv
test/tb_bit_plane_led_frame_store_core.sv
